// ===== rtl/gba_pkg.sv =====
// Shared types and constants for the grouped bitmap allocator.
package gba_pkg;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_GCHK,
        S_ARD,
        S_AEVAL,
        S_FCHK,
        S_FDIV,
        S_FEVAL,
        S_DONE
    } state_t;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFREE  = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;
    localparam logic [1:0] STAT_NOTSET  = 2'd3;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_GROUP_COUNT = 2'd0;
    localparam logic [1:0] REG_ENTRIES     = 2'd1;
    localparam logic [1:0] REG_BASE        = 2'd2;

    // Saturation point of a directory count
    localparam logic [13:0] DIR_LIMIT = 14'd16383;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic       setup;
        logic       grp_next;
        logic       word_next;
        logic       rd;
        logic       alloc_commit;
        logic       free_commit;
        logic       div_step;
        logic       set_status;
        logic [1:0] status;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic grp_end;
        logic grp_full;
        logic found;
        logic last_word;
        logic free_oor;
        logic div_done;
        logic bit_set;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/gba_ram.sv =====
// Generic single-port RAM with registered read.
module gba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/gba_ctrl.sv =====
// Controller state machine of the grouped bitmap allocator.
module gba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gba_pkg::sts_t sts,
    output gba_pkg::cmd_t cmd
);

    import gba_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one request
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = sts.is_free ? S_FCHK : S_GCHK;
            end
            S_GCHK:
            begin
                if (sts.grp_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_NOFREE;
                    state_next     = S_DONE;
                end
                else if (sts.grp_full)
                begin
                    cmd.grp_next = 1'b1;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_AEVAL;
                end
            end
            S_ARD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_AEVAL;
            end
            S_AEVAL:
            begin
                if (sts.found)
                begin
                    cmd.alloc_commit = 1'b1;
                    cmd.set_status   = 1'b1;
                    cmd.status       = STAT_OK;
                    state_next       = S_DONE;
                end
                else if (sts.last_word)
                begin
                    cmd.grp_next = 1'b1;
                    state_next   = S_GCHK;
                end
                else
                begin
                    cmd.word_next = 1'b1;
                    state_next    = S_ARD;
                end
            end
            S_FCHK:
            begin
                if (sts.free_oor)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_RANGE;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_FEVAL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FEVAL:
            begin
                cmd.set_status = 1'b1;
                if (sts.bit_set)
                begin
                    cmd.free_commit = 1'b1;
                    cmd.status      = STAT_OK;
                end
                else
                begin
                    cmd.status = STAT_NOTSET;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gba_dp.sv =====
// Datapath of the grouped bitmap allocator: bitmap store, counters, scan and result.
module gba_dp #(
    parameter int MAX_GROUPS    = 16,
    parameter int MAX_PER_GROUP = 8192
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [4:0]    cfg_group_count,
    input  logic [13:0]   cfg_entries,
    input  logic          cfg_base,
    input  logic          in_action,
    input  logic [17:0]   in_item,
    input  logic          in_dir,
    input  gba_pkg::cmd_t cmd,
    output gba_pkg::sts_t sts,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [1:0]    out_status,
    output logic [17:0]   out_number,
    output logic [17:0]   out_free_cnt
);

    import gba_pkg::*;

    localparam int NGW   = $clog2(MAX_GROUPS + 1);
    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int EW    = $clog2(MAX_PER_GROUP + 1);
    localparam int CW    = $clog2(MAX_GROUPS * MAX_PER_GROUP + 1);
    localparam int WPG   = (MAX_PER_GROUP + 63) / 64;
    localparam int DEPTH = MAX_GROUPS * WPG;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Request and configuration captured at load, capacity at setup
    logic            act_reg;
    logic            dir_reg;
    logic [17:0]     item_reg;
    logic            base_reg;
    logic [NGW-1:0]  ng_reg;
    logic [EW-1:0]   epg_reg;
    logic [CW-1:0]   cap_reg;
    logic [17:0]     rel_reg;

    // Scan position
    logic [NGW-1:0]  g_reg;
    logic [CW-1:0]   gbase_reg;
    logic [EW-1:0]   woff_reg;
    logic [AW-1:0]   clr_addr_reg;

    // Bookkeeping
    logic [EW-1:0]   used_reg [MAX_GROUPS];
    logic [13:0]     dirs_reg [MAX_GROUPS];
    logic [CW-1:0]   total_reg;

    // Result
    logic [1:0]      status_reg;
    logic [17:0]     number_reg;
    logic            out_valid_reg;
    logic [1:0]      out_status_reg;
    logic [17:0]     out_number_reg;
    logic [17:0]     out_free_reg;

    logic [NGW-1:0]  ng_eff;
    logic [EW-1:0]   epg_eff;
    logic [GW-1:0]   gi;
    logic [EW-1:0]   idx;
    logic [AW-1:0]   addr;
    logic            ram_we;
    logic [63:0]     wdata;
    logic [63:0]     rdata;
    logic [EW-1:0]   left;
    logic [63:0]     avail;
    logic [5:0]      enc_b;
    logic [CW-1:0]   free_cnt;

    assign ng_eff  = (int'(cfg_group_count) > MAX_GROUPS) ? NGW'(MAX_GROUPS)
                                                          : NGW'(cfg_group_count);
    assign epg_eff = (int'(cfg_entries) > MAX_PER_GROUP) ? EW'(MAX_PER_GROUP)
                                                        : EW'(cfg_entries);
    assign gi      = g_reg[GW-1:0];

    // Form the word address of the current position
    assign idx  = (act_reg == ACT_FREE) ? rel_reg[EW-1:0] : woff_reg;
    assign addr = cmd.clr_step ? clr_addr_reg
                               : AW'(32'(g_reg) * WPG + 32'(idx >> 6));

    // Mask off bits past the group end, then find the lowest clear bit
    assign left  = epg_reg - woff_reg;
    assign avail = (32'(left) < 64) ? (~rdata & ((64'd1 << left[5:0]) - 64'd1)) : ~rdata;

    always_comb
    begin
        enc_b = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (avail[i])
            begin
                enc_b = 6'(i);
            end
        end
    end

    // Build the word written back
    always_comb
    begin
        if (cmd.clr_step)
        begin
            wdata = '0;
        end
        else if (cmd.alloc_commit)
        begin
            wdata = rdata | (64'd1 << enc_b);
        end
        else
        begin
            wdata = rdata & ~(64'd1 << rel_reg[5:0]);
        end
    end

    assign ram_we = cmd.clr_step | cmd.alloc_commit | cmd.free_commit;

    gba_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.rd),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign free_cnt = (cap_reg > total_reg) ? cap_reg - total_reg : '0;

    // Report status to the controller
    always_comb
    begin
        sts.clr_last  = (32'(clr_addr_reg) == DEPTH - 1);
        sts.is_free   = (act_reg == ACT_FREE);
        sts.grp_end   = (g_reg >= ng_reg);
        sts.grp_full  = (used_reg[gi] >= epg_reg);
        sts.found     = (avail != 64'd0);
        sts.last_word = (32'(woff_reg) + 64 >= 32'(epg_reg));
        sts.free_oor  = (item_reg < 18'(base_reg)) || (32'(rel_reg) >= 32'(cap_reg));
        sts.div_done  = (32'(rel_reg) < 32'(epg_reg));
        sts.bit_set   = rdata[rel_reg[5:0]];
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Capture the request and advance the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= in_action;
            dir_reg    <= in_dir;
            item_reg   <= in_item;
            base_reg   <= cfg_base;
            ng_reg     <= ng_eff;
            epg_reg    <= epg_eff;
            rel_reg    <= in_item - 18'(cfg_base);
            g_reg      <= '0;
            gbase_reg  <= '0;
            woff_reg   <= '0;
            number_reg <= '0;
        end
        else
        begin
            if (cmd.setup)
            begin
                cap_reg <= CW'(ng_reg) * CW'(epg_reg);
            end
            if (cmd.grp_next)
            begin
                g_reg     <= g_reg + NGW'(1);
                gbase_reg <= gbase_reg + CW'(epg_reg);
                woff_reg  <= '0;
            end
            if (cmd.word_next)
            begin
                woff_reg <= woff_reg + EW'(64);
            end
            if (cmd.div_step)
            begin
                rel_reg <= rel_reg - 18'(epg_reg);
                g_reg   <= g_reg + NGW'(1);
            end
            if (cmd.alloc_commit)
            begin
                number_reg <= 18'(32'(base_reg) + 32'(gbase_reg) + 32'(woff_reg)
                                  + 32'(enc_b));
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
        end
    end

    // Step the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Update group and total counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                used_reg[i] <= '0;
                dirs_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (cmd.alloc_commit)
        begin
            used_reg[gi] <= used_reg[gi] + EW'(1);
            if (dir_reg && dirs_reg[gi] < DIR_LIMIT)
            begin
                dirs_reg[gi] <= dirs_reg[gi] + 14'd1;
            end
            total_reg <= total_reg + CW'(1);
        end
        else if (cmd.free_commit)
        begin
            if (used_reg[gi] != '0)
            begin
                used_reg[gi] <= used_reg[gi] - EW'(1);
            end
            if (total_reg != '0)
            begin
                total_reg <= total_reg - CW'(1);
            end
        end
    end

    // Hold the finished item until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_number_reg <= number_reg;
            out_free_reg   <= 18'(free_cnt);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_number   = out_number_reg;
    assign out_free_cnt = out_free_reg;

endmodule

// ===== rtl/grouped_bitmap_allocator.sv =====
// Grouped bitmap allocator: top level with configuration registers and stream ports.
//
// Hands out and returns numbered items kept in per-group usage bitmaps held in a
// 64-bit-wide on-chip RAM. After reset the block sweeps the RAM clear, one word a
// cycle, and accepts no item meanwhile; register writes are taken throughout. One
// request is handled at a time. An allocate sets up, then for each group skips it
// when full or reads and tests its bitmap words in turn (the single RAM port reads
// one word, then tests it), and ends with a no-free status when no group has room.
// A free checks the range, finds the item's group by repeated subtraction, one
// group per step, then reads and tests the word; an out-of-range number ends after
// the range check. The result waits in an output register and the next item is
// accepted once it has been loaded there.
module grouped_bitmap_allocator #(
    parameter int MAX_GROUPS    = 16,
    parameter int MAX_PER_GROUP = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // item_number[17:0], zero pad
    input  logic [1:0]  s_tuser,   // action[0], is_directory[1]
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // allocated_number[17:0], total_free[35:18], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    import gba_pkg::*;

    logic [4:0]  group_count_reg;
    logic [13:0] entries_reg;
    logic        base_reg;
    logic [1:0]  reg_idx;
    cmd_t        cmd;
    sts_t        sts;
    logic [17:0] number;
    logic [17:0] free_cnt;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= 5'd16;
            entries_reg     <= 14'd8192;
            base_reg        <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_GROUP_COUNT: group_count_reg <= pwdata[4:0];
                REG_ENTRIES:     entries_reg     <= pwdata[13:0];
                REG_BASE:        base_reg        <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (reg_idx)
            REG_GROUP_COUNT: prdata = 32'(group_count_reg);
            REG_ENTRIES:     prdata = 32'(entries_reg);
            REG_BASE:        prdata = 32'(base_reg);
            default:         prdata = '0;
        endcase
    end

    gba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gba_dp #(
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_PER_GROUP (MAX_PER_GROUP)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_group_count (group_count_reg),
        .cfg_entries     (entries_reg),
        .cfg_base        (base_reg),
        .in_action       (s_tuser[0]),
        .in_item         (s_tdata[17:0]),
        .in_dir          (s_tuser[1]),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_status      (m_tuser),
        .out_number      (number),
        .out_free_cnt    (free_cnt)
    );

    assign m_tdata = {4'd0, free_cnt, number};

endmodule

// ===== rtl/gba_chk.sv =====
// Port checker for the grouped bitmap allocator, bound to the top level.
module gba_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Drop ready once a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // A failed request gives no number
    a_fail_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 2'd0 |-> m_tdata[17:0] == 18'd0)
        else $error("number given on failed request");

    // Keep the configuration port ready
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind grouped_bitmap_allocator gba_chk u_gba_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
